// ===== hdl/eight_bit_alu_with_flags_defines.svh =====
// Assertion macros shared by the ALU checker.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EBALU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebalu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EBALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebalu assertion failed");

`endif

// ===== hdl/ebalu_pkg.sv =====
// Types and constants for the eight-bit ALU with flags.
`timescale 1ns / 1ps
package ebalu_pkg;

    typedef enum logic [4:0] {
        FN_ADD   = 5'd0,
        FN_ADC   = 5'd1,
        FN_SUB   = 5'd2,
        FN_SBC   = 5'd3,
        FN_AND   = 5'd4,
        FN_XOR   = 5'd5,
        FN_OR    = 5'd6,
        FN_CP    = 5'd7,
        FN_INC   = 5'd8,
        FN_DEC   = 5'd9,
        FN_RLCA  = 5'd10,
        FN_RLA   = 5'd11,
        FN_RRCA  = 5'd12,
        FN_RRA   = 5'd13,
        FN_DAA   = 5'd14,
        FN_CPL   = 5'd15,
        FN_SCF   = 5'd16,
        FN_CCF   = 5'd17,
        FN_ADD16 = 5'd18
    } t_func;

    // Flag bit positions: S Z Y H X PV N C
    localparam int FL_S  = 7;
    localparam int FL_Z  = 6;
    localparam int FL_Y  = 5;
    localparam int FL_H  = 4;
    localparam int FL_X  = 3;
    localparam int FL_PV = 2;
    localparam int FL_N  = 1;
    localparam int FL_C  = 0;

    localparam logic [7:0] C_INC_OVF = 8'h7F;
    localparam logic [7:0] C_DEC_OVF = 8'h80;
    localparam logic [7:0] C_BCD_MAX = 8'h99;
    localparam logic [7:0] C_DAA_LO  = 8'h06;
    localparam logic [7:0] C_DAA_HI  = 8'h60;
    localparam logic [3:0] C_NIB_MAX = 4'd9;
    localparam logic [3:0] C_NIB_SIX = 4'd6;

    typedef struct packed {
        logic [4:0]  func;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [7:0]  flags_in;
        logic [15:0] wide_a;
        logic [15:0] wide_b;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [7:0]  flags_out;
    } t_out_item;

endpackage

// ===== hdl/ebalu_in_if.sv =====
// Input channel: operation item with valid/ready handshake.
`timescale 1ns / 1ps
interface ebalu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [7:0]  flags_in;
    logic [15:0] wide_a;
    logic [15:0] wide_b;

    modport source (
        output valid, func, acc, operand, flags_in, wide_a, wide_b,
        input  ready
    );
    modport sink (
        input  valid, func, acc, operand, flags_in, wide_a, wide_b,
        output ready
    );
endinterface

// ===== hdl/ebalu_out_if.sv =====
// Output channel: result item with valid/ready handshake.
`timescale 1ns / 1ps
interface ebalu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic [7:0]  flags_out;

    modport source (
        output valid, result_byte, result_word, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result_byte, result_word, flags_out,
        output ready
    );
endinterface

// ===== hdl/ebalu_core.sv =====
// Combinational ALU datapath: 8-bit ops, 16-bit add and flag generation.
`timescale 1ns / 1ps
module ebalu_core import ebalu_pkg::*; (
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic       w_cin;
    logic       w_sub;
    logic       w_ci;
    logic [7:0] w_vx;
    logic [8:0] w_s9;
    logic [4:0] w_s5;
    logic [7:0] w_ar;
    logic [7:0] w_af;

    // Shared add/subtract unit for add, adc, sub, sbc and cp
    always_comb begin
        w_cin = i_item.flags_in[FL_C] &
                ((i_item.func == FN_ADC) || (i_item.func == FN_SBC));
        w_sub = (i_item.func == FN_SUB) || (i_item.func == FN_SBC) ||
                (i_item.func == FN_CP);
        w_ci  = w_sub ^ w_cin;
        w_vx  = w_sub ? ~i_item.operand : i_item.operand;
        w_s9  = {1'b0, i_item.acc} + {1'b0, w_vx} + {8'd0, w_ci};
        w_s5  = {1'b0, i_item.acc[3:0]} + {1'b0, w_vx[3:0]} + {4'd0, w_ci};
        w_ar  = w_s9[7:0];
        w_af  = {w_ar[7], w_ar == 8'd0, w_ar[5], w_sub ^ w_s5[4], w_ar[3],
                 ~(i_item.acc[7] ^ w_vx[7]) & (i_item.acc[7] ^ w_ar[7]),
                 w_sub, w_sub ^ w_s9[8]};
    end

    always_comb begin
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  f;
        logic [7:0]  rb;
        logic [7:0]  corr;
        logic        lo_big;
        logic        h;
        logic        c;
        logic [16:0] s17;
        logic [12:0] s13;

        a    = i_item.acc;
        v    = i_item.operand;
        f    = i_item.flags_in;
        rb   = a;
        corr = 8'd0;
        h    = 1'b0;
        c    = 1'b0;
        lo_big = a[3:0] > C_NIB_MAX;
        s17  = {1'b0, i_item.wide_a} + {1'b0, i_item.wide_b};
        s13  = {1'b0, i_item.wide_a[11:0]} + {1'b0, i_item.wide_b[11:0]};

        o_result.result_byte = a;
        o_result.result_word = 16'd0;
        o_result.flags_out   = f;

        unique case (i_item.func)
            FN_ADD, FN_ADC, FN_SUB, FN_SBC: begin
                o_result.result_byte = w_ar;
                o_result.flags_out   = w_af;
            end
            FN_CP: begin
                o_result.flags_out        = w_af;
                o_result.flags_out[FL_Y]  = v[FL_Y];
                o_result.flags_out[FL_X]  = v[FL_X];
            end
            FN_AND, FN_XOR, FN_OR: begin
                if (i_item.func == FN_AND) begin
                    rb = a & v;
                end else if (i_item.func == FN_XOR) begin
                    rb = a ^ v;
                end else begin
                    rb = a | v;
                end
                o_result.result_byte = rb;
                o_result.flags_out   = {rb[7], rb == 8'd0, rb[5], i_item.func == FN_AND,
                                        rb[3], ~^rb, 1'b0, 1'b0};
            end
            FN_INC: begin
                rb = v + 8'd1;
                o_result.result_byte = rb;
                o_result.flags_out   = {rb[7], rb == 8'd0, rb[5], v[3:0] == 4'hF,
                                        rb[3], v == C_INC_OVF, 1'b0, f[FL_C]};
            end
            FN_DEC: begin
                rb = v - 8'd1;
                o_result.result_byte = rb;
                o_result.flags_out   = {rb[7], rb == 8'd0, rb[5], v[3:0] == 4'h0,
                                        rb[3], v == C_DEC_OVF, 1'b1, f[FL_C]};
            end
            FN_RLCA, FN_RLA, FN_RRCA, FN_RRA: begin
                if (i_item.func == FN_RLCA) begin
                    rb = {a[6:0], a[7]};
                    c  = a[7];
                end else if (i_item.func == FN_RLA) begin
                    rb = {a[6:0], f[FL_C]};
                    c  = a[7];
                end else if (i_item.func == FN_RRCA) begin
                    rb = {a[0], a[7:1]};
                    c  = a[0];
                end else begin
                    rb = {f[FL_C], a[7:1]};
                    c  = a[0];
                end
                o_result.result_byte = rb;
                o_result.flags_out   = {f[FL_S], f[FL_Z], rb[5], 1'b0,
                                        rb[3], f[FL_PV], 1'b0, c};
            end
            FN_DAA: begin
                if (f[FL_H] || lo_big) begin
                    corr = corr | C_DAA_LO;
                end
                c = f[FL_C];
                if ((a > C_BCD_MAX) || f[FL_C]) begin
                    corr = corr | C_DAA_HI;
                    c    = 1'b1;
                end
                if (f[FL_N]) begin
                    h  = f[FL_H] && (a[3:0] < C_NIB_SIX);
                    rb = a - corr;
                end else begin
                    h  = lo_big;
                    rb = a + corr;
                end
                o_result.result_byte = rb;
                o_result.flags_out   = {rb[7], rb == 8'd0, rb[5], h,
                                        rb[3], ~^rb, f[FL_N], c};
            end
            FN_CPL: begin
                rb = ~a;
                o_result.result_byte = rb;
                o_result.flags_out   = {f[FL_S], f[FL_Z], rb[5], 1'b1,
                                        rb[3], f[FL_PV], 1'b1, f[FL_C]};
            end
            FN_SCF: begin
                o_result.flags_out = {f[FL_S], f[FL_Z], a[5], 1'b0,
                                      a[3], f[FL_PV], 1'b0, 1'b1};
            end
            FN_CCF: begin
                o_result.flags_out = {f[FL_S], f[FL_Z], a[5], f[FL_C],
                                      a[3], f[FL_PV], 1'b0, ~f[FL_C]};
            end
            FN_ADD16: begin
                o_result.result_word = s17[15:0];
                o_result.flags_out   = {f[FL_S], f[FL_Z], s17[13], s13[12],
                                        s17[11], f[FL_PV], 1'b0, s17[16]};
            end
            default: begin
                o_result.result_byte = a;
            end
        endcase
    end

endmodule

// ===== hdl/eight_bit_alu_with_flags.sv =====
// Top level of the eight-bit ALU with flags: input register, datapath, result register.
// Takes one item per cycle while the result side is not stalled and returns one result
// per item, in order. An accepted item is held in the input register, then passes through
// the ALU datapath into the result register. Throughput of one item per clock is set by
// the two-entry register chain; input ready depends combinationally on output ready when
// both registers are full.
`timescale 1ns / 1ps
module eight_bit_alu_with_flags import ebalu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ebalu_in_if.sink           i_item,
    ebalu_out_if.source        o_result
);

    logic      r_in_valid;
    logic      n_in_valid;
    logic      r_out_valid;
    logic      n_out_valid;
    t_in_item  r_in;
    t_out_item r_out;
    t_out_item w_alu;
    logic      w_out_free;
    logic      w_in_acc;

    ebalu_core u_core (
        .i_item   (r_in),
        .o_result (w_alu)
    );

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_in_valid || w_out_free;
    assign w_in_acc     = i_item.valid && i_item.ready;

    assign n_in_valid  = w_in_acc || (r_in_valid && !w_out_free);
    assign n_out_valid = r_in_valid || (r_out_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= '{func:     i_item.func,
                      acc:      i_item.acc,
                      operand:  i_item.operand,
                      flags_in: i_item.flags_in,
                      wide_a:   i_item.wide_a,
                      wide_b:   i_item.wide_b};
        end
        if (r_in_valid && w_out_free) begin
            r_out <= w_alu;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_byte = r_out.result_byte;
    assign o_result.result_word = r_out.result_word;
    assign o_result.flags_out   = r_out.flags_out;

endmodule

// ===== hdl/ebalu_checker.sv =====
// Port-level checker for the eight-bit ALU with flags, bound to the top level.
`timescale 1ns / 1ps
`include "eight_bit_alu_with_flags_defines.svh"
module ebalu_prop_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_result_byte,
    input logic [15:0] i_result_word,
    input logic [7:0]  i_flags_out
);

    logic [31:0] w_payload;
    logic        w_in_acc;

    assign w_payload = {i_result_byte, i_result_word, i_flags_out};
    assign w_in_acc  = i_in_valid && i_in_ready;

    // An item accepted and then met by an open result side shows up as a valid result
    `EBALU_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_acc ##1 i_out_ready, i_out_valid)
    // With no result pending the input side is always open
    `EBALU_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `EBALU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `EBALU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(w_payload))

endmodule

bind eight_bit_alu_with_flags ebalu_prop_checker u_ebalu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_result_byte (o_result.result_byte),
    .i_result_word (o_result.result_word),
    .i_flags_out   (o_result.flags_out)
);
